// ===== rtl/mst_pkg.sv =====
// constants and types for the kruskal spanning tree unit
// used by minimum_spanning_tree_kruskal_unit; no dependencies
`timescale 1ns / 1ps
package mst_pkg;
   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 1024;
   localparam int WgtW        = 16;
   localparam int CostW       = 22;
   localparam int VtxW        = $clog2(MaxVertices);
   localparam int CfgW        = VtxW + 1;
   localparam int AddrW       = $clog2(MaxEdges);
   localparam int CntW        = $clog2(MaxEdges + 1);
   localparam int RankW       = 3;
   localparam int EdgeW       = 2 * VtxW + WgtW;
   localparam int NodeW       = RankW + VtxW;
   localparam logic [RankW-1:0] RankMax = '1;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN_RD  = 9'b000000010,
      S_SCAN_CMP = 9'b000000100,
      S_PICK     = 9'b000001000,
      S_FIND_RD  = 9'b000010000,
      S_FIND_CHK = 9'b000100000,
      S_JOIN     = 9'b001000000,
      S_BUMP     = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;
endpackage

// ===== rtl/minimum_spanning_tree_kruskal_unit.sv =====
// kruskal minimum spanning tree: edge store, min-selection scan, union-find
// depends on mst_pkg
`timescale 1ns / 1ps
// Usage
//   Edges enter one word per cycle on req_* while start is high and busy low.
//   An edge with an endpoint at or above the vertex count is ignored; once the
//   1024-entry edge store is full further edges are dropped and flagged.
//   The word with req_final_edge set starts the tree run and busy rises.
//   The run repeatedly scans the edge store (a read and a compare state per
//   stored edge) to pick the next edge in (weight, arrival) order, then walks
//   the union-find table (a read and a check state per parent hop) and joins
//   the two roots when they differ. Each accepted edge comes out for one cycle
//   with rsp_strobe, one result behind its acceptance; the last result carries
//   rsp_run_end. With no edge accepted one empty result with rsp_run_end is
//   given. The receiver cannot stall. At the end of a run, and at reset, the
//   store count, overflow flag and union-find table are cleared. csr_we writes
//   the vertex count (0 acts as 1, above 64 acts as 64); reset sets it to 64.
//   The user must write it only while idle; the block does not enforce this.
module minimum_spanning_tree_kruskal_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mst_pkg::VtxW-1:0]        req_end_a,
   input  logic [mst_pkg::VtxW-1:0]        req_end_b,
   input  logic signed [mst_pkg::WgtW-1:0] req_edge_weight,
   input  logic                            req_final_edge,
   input  logic                            csr_we,
   input  logic [mst_pkg::CfgW-1:0]        csr_wdata,
   output logic                            rsp_strobe,
   output logic                            rsp_has_edge,
   output logic [mst_pkg::VtxW-1:0]        rsp_tree_a,
   output logic [mst_pkg::VtxW-1:0]        rsp_tree_b,
   output logic signed [mst_pkg::WgtW-1:0] rsp_tree_weight,
   output logic signed [mst_pkg::CostW-1:0] rsp_running_cost,
   output logic                            rsp_store_overflow,
   output logic                            rsp_run_end
);
   import mst_pkg::*;

   // memories
   logic [EdgeW-1:0] edge_mem [MaxEdges];
   logic [NodeW-1:0] node_mem [MaxVertices];

   state_type state_ff, state_in;
   logic [CfgW-1:0] vcount_ff, vcount_in;
   logic [CntW-1:0] total_ff, total_in, ptr_ff, ptr_in;
   logic dropped_ff, dropped_in;
   logic [MaxVertices-1:0] nvalid_ff, nvalid_in;
   logic [EdgeW-1:0] erd_ff;
   logic [NodeW-1:0] nrd_ff;
   logic nrd_vld_ff;
   // selection
   logic found_ff, found_in, have_prev_ff, have_prev_in;
   logic [CntW-1:0] best_i_ff, best_i_in, prev_i_ff, prev_i_in;
   logic signed [WgtW-1:0] best_w_ff, best_w_in, prev_w_ff, prev_w_in;
   logic [VtxW-1:0] best_a_ff, best_a_in, best_b_ff, best_b_in;
   // union-find walk
   logic side_ff, side_in;
   logic [VtxW-1:0] cur_ff, cur_in, ra_ff, ra_in;
   logic [RankW-1:0] rka_ff, rka_in;
   // tree accounting
   logic signed [CostW-1:0] cost_ff, cost_in;
   logic [VtxW-1:0] acc_ff, acc_in;
   logic pend_ff, pend_in;
   logic [VtxW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [WgtW-1:0] pw_ff, pw_in;
   logic signed [CostW-1:0] pc_ff, pc_in;
   // result word
   logic o_stb_ff, o_stb_in, o_has_ff, o_has_in, o_ovf_ff, o_ovf_in, o_end_ff, o_end_in;
   logic [VtxW-1:0] o_a_ff, o_a_in, o_b_ff, o_b_in;
   logic signed [WgtW-1:0] o_w_ff, o_w_in;
   logic signed [CostW-1:0] o_c_ff, o_c_in;

   logic [CfgW-1:0] nv;
   logic [VtxW-1:0] target;
   logic in_range, e_we, n_we;
   logic [AddrW-1:0] e_waddr, e_raddr;
   logic [EdgeW-1:0] e_wdata;
   logic [VtxW-1:0] n_addr, n_waddr;
   logic [NodeW-1:0] n_wdata;
   logic [VtxW-1:0] c_a, c_b, par;
   logic signed [WgtW-1:0] c_w;
   logic [RankW-1:0] rk;
   logic better;

   // live vertex count and tree size
   always_comb begin
      if (vcount_ff == '0) nv = CfgW'(1);
      else if (vcount_ff > CfgW'(MaxVertices)) nv = CfgW'(MaxVertices);
      else nv = vcount_ff;
      target = VtxW'(nv - CfgW'(1));
   end

   assign in_range = ({1'b0, req_end_a} < nv) && ({1'b0, req_end_b} < nv);
   assign {c_a, c_b, c_w} = erd_ff;
   assign par = nrd_vld_ff ? nrd_ff[VtxW-1:0] : cur_ff;
   assign rk  = nrd_vld_ff ? nrd_ff[NodeW-1:VtxW] : '0;
   // scan runs in rising index order, so a tie never beats the current best
   assign better = (!have_prev_ff || c_w > prev_w_ff
                    || (c_w == prev_w_ff && (ptr_ff - CntW'(1)) > prev_i_ff))
                   && (!found_ff || c_w < best_w_ff);

   // sequencer
   always_comb begin
      state_in = state_ff; vcount_in = vcount_ff; total_in = total_ff; ptr_in = ptr_ff;
      dropped_in = dropped_ff; nvalid_in = nvalid_ff;
      found_in = found_ff; have_prev_in = have_prev_ff; best_i_in = best_i_ff;
      prev_i_in = prev_i_ff; best_w_in = best_w_ff; prev_w_in = prev_w_ff;
      best_a_in = best_a_ff; best_b_in = best_b_ff;
      side_in = side_ff; cur_in = cur_ff; ra_in = ra_ff; rka_in = rka_ff;
      cost_in = cost_ff; acc_in = acc_ff; pend_in = pend_ff;
      pa_in = pa_ff; pb_in = pb_ff; pw_in = pw_ff; pc_in = pc_ff;
      o_stb_in = 1'b0; o_has_in = o_has_ff; o_ovf_in = o_ovf_ff; o_end_in = o_end_ff;
      o_a_in = o_a_ff; o_b_in = o_b_ff; o_w_in = o_w_ff; o_c_in = o_c_ff;
      e_we = 1'b0; e_waddr = total_ff[AddrW-1:0];
      e_wdata = {req_end_a, req_end_b, req_edge_weight};
      e_raddr = ptr_ff[AddrW-1:0];
      n_we = 1'b0; n_addr = cur_ff; n_waddr = ra_ff; n_wdata = '0;

      if (csr_we) vcount_in = csr_wdata;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (in_range) begin
                  if (total_ff < CntW'(MaxEdges)) begin
                     e_we = 1'b1;
                     total_in = total_ff + CntW'(1);
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
               if (req_final_edge) begin
                  ptr_in = '0; found_in = 1'b0; have_prev_in = 1'b0;
                  state_in = (target == '0) ? S_DONE : S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (ptr_ff == total_ff) state_in = S_PICK;
            else begin
               ptr_in = ptr_ff + CntW'(1);
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (better) begin
               found_in = 1'b1; best_w_in = c_w; best_i_in = ptr_ff - CntW'(1);
               best_a_in = c_a; best_b_in = c_b;
            end
            state_in = S_SCAN_RD;
         end
         S_PICK: begin
            if (!found_ff) state_in = S_DONE;
            else begin
               have_prev_in = 1'b1; prev_w_in = best_w_ff; prev_i_in = best_i_ff;
               ptr_in = '0; found_in = 1'b0;
               if ({1'b0, best_a_ff} >= nv || {1'b0, best_b_ff} >= nv) state_in = S_SCAN_RD;
               else begin
                  cur_in = best_a_ff; side_in = 1'b0; state_in = S_FIND_RD;
               end
            end
         end
         S_FIND_RD: state_in = S_FIND_CHK;
         S_FIND_CHK: begin
            if (par != cur_ff) begin
               cur_in = par; state_in = S_FIND_RD;
            end else if (!side_ff) begin
               ra_in = cur_ff; rka_in = rk; cur_in = best_b_ff; side_in = 1'b1;
               state_in = S_FIND_RD;
            end else if (ra_ff == cur_ff) begin
               state_in = S_SCAN_RD;
            end else begin
               // join by rank; cur holds the second root
               n_we = 1'b1;
               if (rka_ff < rk) begin
                  n_waddr = ra_ff; n_wdata = {rka_ff, cur_ff};
               end else begin
                  n_waddr = cur_ff; n_wdata = {rk, ra_ff};
               end
               cost_in = cost_ff + CostW'(best_w_ff);
               acc_in = acc_ff + VtxW'(1);
               if (pend_ff) begin
                  o_stb_in = 1'b1; o_has_in = 1'b1; o_end_in = 1'b0; o_ovf_in = dropped_ff;
                  o_a_in = pa_ff; o_b_in = pb_ff; o_w_in = pw_ff; o_c_in = pc_ff;
               end
               pend_in = 1'b1; pa_in = best_a_ff; pb_in = best_b_ff; pw_in = best_w_ff;
               pc_in = cost_ff + CostW'(best_w_ff);
               state_in = (rka_ff == rk && rka_ff != RankMax) ? S_BUMP : S_JOIN;
            end
         end
         S_JOIN: state_in = (acc_ff == target) ? S_DONE : S_SCAN_RD;
         S_BUMP: begin
            n_we = 1'b1; n_waddr = ra_ff; n_wdata = {rka_ff + RankW'(1), ra_ff};
            state_in = (acc_ff == target) ? S_DONE : S_SCAN_RD;
         end
         S_DONE: begin
            o_stb_in = 1'b1; o_end_in = 1'b1; o_ovf_in = dropped_ff; o_has_in = pend_ff;
            o_a_in = pend_ff ? pa_ff : '0; o_b_in = pend_ff ? pb_ff : '0;
            o_w_in = pend_ff ? pw_ff : '0; o_c_in = pend_ff ? pc_ff : '0;
            total_in = '0; dropped_in = 1'b0; nvalid_in = '0; cost_in = '0; acc_in = '0;
            pend_in = 1'b0; have_prev_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (n_we) nvalid_in[n_waddr] = 1'b1;
   end

   // edge store, registered read
   always_ff @(posedge clock) begin
      if (e_we) edge_mem[e_waddr] <= e_wdata;
      erd_ff <= edge_mem[e_raddr];
   end

   // union-find table, registered read
   always_ff @(posedge clock) begin
      if (n_we) node_mem[n_waddr] <= n_wdata;
      nrd_ff <= node_mem[n_addr];
      nrd_vld_ff <= nvalid_ff[n_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vcount_ff <= CfgW'(MaxVertices); total_ff <= '0;
         dropped_ff <= 1'b0; nvalid_ff <= '0; found_ff <= 1'b0; have_prev_ff <= 1'b0;
         cost_ff <= '0; acc_ff <= '0; pend_ff <= 1'b0; o_stb_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vcount_ff <= vcount_in; total_ff <= total_in;
         dropped_ff <= dropped_in; nvalid_ff <= nvalid_in; found_ff <= found_in;
         have_prev_ff <= have_prev_in; cost_ff <= cost_in; acc_ff <= acc_in;
         pend_ff <= pend_in; o_stb_ff <= o_stb_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in; best_i_ff <= best_i_in; prev_i_ff <= prev_i_in;
      best_w_ff <= best_w_in; prev_w_ff <= prev_w_in; best_a_ff <= best_a_in;
      best_b_ff <= best_b_in; side_ff <= side_in; cur_ff <= cur_in; ra_ff <= ra_in;
      rka_ff <= rka_in; pa_ff <= pa_in; pb_ff <= pb_in; pw_ff <= pw_in; pc_ff <= pc_in;
      o_has_ff <= o_has_in; o_ovf_ff <= o_ovf_in; o_end_ff <= o_end_in;
      o_a_ff <= o_a_in; o_b_ff <= o_b_in; o_w_ff <= o_w_in; o_c_ff <= o_c_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = o_stb_ff;
   assign rsp_has_edge = o_has_ff;
   assign rsp_tree_a = o_a_ff;
   assign rsp_tree_b = o_b_ff;
   assign rsp_tree_weight = o_w_ff;
   assign rsp_running_cost = o_c_ff;
   assign rsp_store_overflow = o_ovf_ff;
   assign rsp_run_end = o_end_ff;

   // checks
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_run_end |-> state_ff == S_IDLE) else $error("run end while busy");
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_has_edge |-> rsp_run_end) else $error("empty result not last");
   a_acc_cap: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= target) else $error("too many tree edges");
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CntW'(MaxEdges)) else $error("edge count past store");
endmodule

// ===== tb/tb_minimum_spanning_tree_kruskal_unit.sv =====
// testbench for the kruskal spanning tree unit: random and directed graphs,
// results checked against a behavioral kruskal predictor in a scoreboard class
// depends on mst_pkg and minimum_spanning_tree_kruskal_unit
`timescale 1ns / 1ps
module tb_minimum_spanning_tree_kruskal_unit;
   import mst_pkg::*;

   localparam int CycleLimit = 3000000;

   typedef struct {
      logic                    has_edge;
      logic [VtxW-1:0]         tree_a;
      logic [VtxW-1:0]         tree_b;
      logic signed [WgtW-1:0]  tree_weight;
      logic signed [CostW-1:0] running_cost;
      logic                    store_overflow;
      logic                    run_end;
   } tree_word_type;

   // kruskal predictor plus queue of expected tree words
   class mst_scoreboard;
      int unsigned             vtx_setting;
      logic [VtxW-1:0]         held_a[$];
      logic [VtxW-1:0]         held_b[$];
      logic signed [WgtW-1:0]  held_w[$];
      bit                      lost_edges;
      tree_word_type           pending[$];
      int                      errors;

      function new();
         vtx_setting = MaxVertices;
         lost_edges  = 1'b0;
         errors      = 0;
      endfunction

      function int unsigned live_vertices();
         if (vtx_setting < 1) return 1;
         if (vtx_setting > MaxVertices) return MaxVertices;
         return vtx_setting;
      endfunction

      function void write_vertices(int unsigned v);
         vtx_setting = v;
      endfunction

      // one accepted input word; a final word builds the whole tree
      function void note_edge(logic [VtxW-1:0] a, logic [VtxW-1:0] b,
                              logic signed [WgtW-1:0] w, logic last);
         int unsigned nv;
         int unsigned n;
         int unsigned picked;
         int order[$];
         int parent[MaxVertices];
         int rnk[MaxVertices];
         int j, t, ra, rb, x;
         logic signed [CostW-1:0] cost;
         tree_word_type tw;
         nv = live_vertices();
         if (a < nv && b < nv) begin
            if (held_a.size() < MaxEdges) begin
               held_a.push_back(a);
               held_b.push_back(b);
               held_w.push_back(w);
            end else begin
               lost_edges = 1'b1;
            end
         end
         if (!last) return;
         // stable insertion sort of indexes by weight
         n = held_a.size();
         for (int i = 0; i < n; i++) order.push_back(i);
         for (int i = 1; i < n; i++) begin
            t = order[i];
            j = i;
            while (j > 0 && held_w[order[j-1]] > held_w[t]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = t;
         end
         for (int i = 0; i < MaxVertices; i++) begin
            parent[i] = i;
            rnk[i] = 0;
         end
         cost = '0;
         picked = 0;
         for (int i = 0; i < n && picked < nv - 1; i++) begin
            // stored edges are checked again against the live vertex count
            if (held_a[order[i]] >= nv || held_b[order[i]] >= nv) continue;
            x = int'(held_a[order[i]]);
            while (parent[x] != x) x = parent[x];
            ra = x;
            x = int'(held_b[order[i]]);
            while (parent[x] != x) x = parent[x];
            rb = x;
            if (ra == rb) continue;
            if (rnk[ra] < rnk[rb]) parent[ra] = rb;
            else if (rnk[ra] > rnk[rb]) parent[rb] = ra;
            else begin
               parent[rb] = ra;
               if (rnk[ra] < 7) rnk[ra]++;
            end
            cost = cost + CostW'(held_w[order[i]]);
            picked++;
            tw.has_edge       = 1'b1;
            tw.tree_a         = held_a[order[i]];
            tw.tree_b         = held_b[order[i]];
            tw.tree_weight    = held_w[order[i]];
            tw.running_cost   = cost;
            tw.store_overflow = lost_edges;
            tw.run_end        = 1'b0;
            pending.push_back(tw);
         end
         if (picked == 0) begin
            tw.has_edge       = 1'b0;
            tw.tree_a         = '0;
            tw.tree_b         = '0;
            tw.tree_weight    = '0;
            tw.running_cost   = '0;
            tw.store_overflow = lost_edges;
            tw.run_end        = 1'b1;
            pending.push_back(tw);
         end else begin
            pending[pending.size()-1].run_end = 1'b1;
         end
         held_a.delete();
         held_b.delete();
         held_w.delete();
         lost_edges = 1'b0;
      endfunction

      // compare one tree word with the oldest expectation
      function void check_word(tree_word_type got);
         tree_word_type exp_w;
         if (pending.size() == 0) begin
            $error("tree word with nothing expected");
            errors++;
            return;
         end
         exp_w = pending.pop_front();
         if (got.has_edge !== exp_w.has_edge) begin
            $error("has_edge exp %0d got %0d", exp_w.has_edge, got.has_edge);
            errors++;
         end
         if (got.tree_a !== exp_w.tree_a) begin
            $error("tree_a exp %0d got %0d", exp_w.tree_a, got.tree_a);
            errors++;
         end
         if (got.tree_b !== exp_w.tree_b) begin
            $error("tree_b exp %0d got %0d", exp_w.tree_b, got.tree_b);
            errors++;
         end
         if (got.tree_weight !== exp_w.tree_weight) begin
            $error("tree_weight exp %0d got %0d", exp_w.tree_weight, got.tree_weight);
            errors++;
         end
         if (got.running_cost !== exp_w.running_cost) begin
            $error("running_cost exp %0d got %0d", exp_w.running_cost,
                   got.running_cost);
            errors++;
         end
         if (got.store_overflow !== exp_w.store_overflow) begin
            $error("store_overflow exp %0d got %0d", exp_w.store_overflow,
                   got.store_overflow);
            errors++;
         end
         if (got.run_end !== exp_w.run_end) begin
            $error("run_end exp %0d got %0d", exp_w.run_end, got.run_end);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    start = 0;
   logic                    busy;
   logic [VtxW-1:0]         req_end_a = '0;
   logic [VtxW-1:0]         req_end_b = '0;
   logic signed [WgtW-1:0]  req_edge_weight = '0;
   logic                    req_final_edge = 0;
   logic                    csr_we = 0;
   logic [CfgW-1:0]         csr_wdata = '0;
   logic                    rsp_strobe;
   logic                    rsp_has_edge;
   logic [VtxW-1:0]         rsp_tree_a;
   logic [VtxW-1:0]         rsp_tree_b;
   logic signed [WgtW-1:0]  rsp_tree_weight;
   logic signed [CostW-1:0] rsp_running_cost;
   logic                    rsp_store_overflow;
   logic                    rsp_run_end;

   mst_scoreboard tree_sb = new();
   int unsigned   cycle_count = 0;
   int            burst_left = 0;
   bit            gaps_on = 1;

   minimum_spanning_tree_kruskal_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_end_a          (req_end_a),
      .req_end_b          (req_end_b),
      .req_edge_weight    (req_edge_weight),
      .req_final_edge     (req_final_edge),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_has_edge       (rsp_has_edge),
      .rsp_tree_a         (rsp_tree_a),
      .rsp_tree_b         (rsp_tree_b),
      .rsp_tree_weight    (rsp_tree_weight),
      .rsp_running_cost   (rsp_running_cost),
      .rsp_store_overflow (rsp_store_overflow),
      .rsp_run_end        (rsp_run_end)
   );

   // 10 ns clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[minimum_spanning_tree_kruskal_unit] ERROR");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      tree_word_type got;
      if (!reset && rsp_strobe) begin
         got.has_edge       = rsp_has_edge;
         got.tree_a         = rsp_tree_a;
         got.tree_b         = rsp_tree_b;
         got.tree_weight    = rsp_tree_weight;
         got.running_cost   = rsp_running_cost;
         got.store_overflow = rsp_store_overflow;
         got.run_end        = rsp_run_end;
         tree_sb.check_word(got);
      end
   end

   // send one edge word, with bursty gaps in front
   task automatic send_edge(logic [VtxW-1:0] a, logic [VtxW-1:0] b,
                            logic signed [WgtW-1:0] w, logic last);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            start = 0;
            req_end_a = VtxW'($urandom);
            req_end_b = VtxW'($urandom);
            req_edge_weight = WgtW'($urandom);
            req_final_edge = 1'($urandom);
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      start = 1;
      req_end_a = a;
      req_end_b = b;
      req_edge_weight = w;
      req_final_edge = last;
      do @(posedge clock); while (busy);
      tree_sb.note_edge(a, b, w, last);
   endtask

   // let the tree run finish, then write the vertex count
   task automatic set_vertices(logic [CfgW-1:0] v);
      @(negedge clock);
      start = 0;
      while (tree_sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      csr_we = 1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      csr_wdata = CfgW'($urandom);
      tree_sb.write_vertices(32'(v));
   endtask

   // one random graph of a few edges, mostly in range
   task automatic random_graph(int unsigned nv);
      int unsigned n;
      logic [VtxW-1:0] a, b;
      logic signed [WgtW-1:0] w;
      n = $urandom_range(0, 14);
      for (int i = 0; i <= n; i++) begin
         if ($urandom_range(0, 9) < 8) begin
            a = VtxW'($urandom_range(0, nv - 1));
            b = VtxW'($urandom_range(0, nv - 1));
         end else begin
            a = VtxW'($urandom);
            b = VtxW'($urandom);
         end
         case ($urandom_range(0, 2))
            0: w = $signed(16'($urandom_range(0, 6))) - 16'sd3;
            1: w = WgtW'($urandom);
            default: w = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         endcase
         send_edge(a, b, w, i == n);
      end
   endtask

   initial begin
      int unsigned nv;
      logic [CfgW-1:0] v;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, self loop, ties, out of range, empty graph
      gaps_on = 0;
      send_edge(6'd0, 6'd63, 16'sh7fff, 0);
      send_edge(6'd63, 6'd0, 16'sh8000, 0);
      send_edge(6'd5, 6'd5, -16'sd7, 0);
      send_edge(6'd1, 6'd2, 16'sd4, 0);
      send_edge(6'd2, 6'd3, 16'sd4, 0);
      send_edge(6'd1, 6'd3, 16'sd4, 0);
      send_edge(6'd3, 6'd63, 16'sd0, 1);
      set_vertices(7'd4);
      send_edge(6'd4, 6'd1, 16'sd1, 0);
      send_edge(6'd0, 6'd1, 16'sd9, 0);
      send_edge(6'd2, 6'd3, -16'sd9, 0);
      send_edge(6'd63, 6'd0, 16'sd3, 1);
      send_edge(6'd9, 6'd9, 16'sd3, 1);
      set_vertices(7'd0);
      send_edge(6'd0, 6'd0, 16'sd5, 1);
      set_vertices(7'd127);
      for (int i = 0; i < 8; i++) send_edge(6'(i), 6'(i + 1), 16'sh8000, i == 7);

      // store overflow: two vertices, one more edge than the store holds
      set_vertices(7'd2);
      for (int i = 0; i <= MaxEdges; i++)
         send_edge(6'd0, 6'd1, WgtW'($urandom), i == MaxEdges);
      send_edge(6'd1, 6'd0, 16'sd2, 1);

      // random phases over several vertex settings
      for (int p = 0; p < 10; p++) begin
         case (p)
            0: v = 7'd64;
            1: v = 7'd1;
            2: v = 7'd2;
            3: v = 7'd100;
            default: v = CfgW'($urandom_range(0, 127));
         endcase
         set_vertices(v);
         gaps_on = (p % 3) != 0;
         nv = tree_sb.live_vertices();
         repeat (2) random_graph(nv);
      end

      @(negedge clock);
      start = 0;
      while (tree_sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (tree_sb.errors == 0 && tree_sb.pending.size() == 0)
         $display("[minimum_spanning_tree_kruskal_unit] OK");
      else
         $display("[minimum_spanning_tree_kruskal_unit] ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/mst_pkg.sv
rtl/minimum_spanning_tree_kruskal_unit.sv
tb/tb_minimum_spanning_tree_kruskal_unit.sv
